// ===== sv/char_lcd_nibble_writer_unit_assert.svh =====
// Assertion macros for the nibble writer's sequencer module.
`ifndef CHAR_LCD_NIBBLE_WRITER_UNIT_ASSERT_SVH
`define CHAR_LCD_NIBBLE_WRITER_UNIT_ASSERT_SVH

// Same-cycle implication, muted while in reset.
`define CLNW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, muted while in reset.
`define CLNW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/clnw_pkg.sv =====
// Shared types, codes and tables for the character LCD nibble writer.
package clnw_pkg;

  typedef enum logic [2:0] {
    ACT_INIT   = 3'd0,
    ACT_CMD    = 3'd1,
    ACT_CHAR   = 3'd2,
    ACT_NUMBER = 3'd3,
    ACT_CURSOR = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_INIT = 2'd1,
    MODE_BYTE = 2'd2,
    MODE_DEC  = 2'd3
  } mode_t;

  localparam logic [1:0] ROW_TOP    = 2'd1;
  localparam logic [1:0] ROW_BOTTOM = 2'd2;
  localparam logic [7:0] ROW_TOP_BASE    = 8'h80;
  localparam logic [7:0] ROW_BOTTOM_BASE = 8'hC0;
  localparam logic [3:0] DIGIT_HI   = 4'h3;  // high nibble of ASCII '0'..'9'
  localparam logic [3:0] INIT_LAST  = 4'd11;
  localparam logic [2:0] POW_LAST   = 3'd4;
  localparam logic       RS_CMD     = 1'b0;
  localparam logic       RS_DATA    = 1'b1;

  // One decoded item as handed to the sequencer.
  typedef struct packed {
    mode_t       mode;
    logic        rs;
    logic [7:0]  data;
    logic [15:0] rem;
    logic [2:0]  pow;
  } job_t;

  // Init sequence: 3,3,3,2 then 0x28, 0x08, 0x0C, 0x01 high nibble first.
  function automatic logic [3:0] init_nibble(input logic [3:0] idx);
    logic [3:0] nib;
    case (idx)
      4'd0, 4'd1, 4'd2: nib = 4'h3;
      4'd3, 4'd4:       nib = 4'h2;
      4'd5, 4'd7:       nib = 4'h8;
      4'd9:             nib = 4'hC;
      4'd11:            nib = 4'h1;
      default:          nib = 4'h0;
    endcase
    return nib;
  endfunction

  function automatic logic [13:0] pow10(input logic [2:0] idx);
    logic [13:0] p;
    case (idx)
      3'd0:    p = 14'd10000;
      3'd1:    p = 14'd1000;
      3'd2:    p = 14'd100;
      3'd3:    p = 14'd10;
      default: p = 14'd1;
    endcase
    return p;
  endfunction

endpackage

// ===== sv/clnw_in_stage.sv =====
// Input register and item decoder for the nibble writer.
module clnw_in_stage
  import clnw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_action,
  input  logic [7:0]  in_byte_value,
  input  logic [15:0] in_number,
  input  logic [5:0]  in_column,
  input  logic [1:0]  in_row,
  output logic        job_valid,
  input  logic        job_ready,
  output job_t        job
);

  logic        buf_v_r;
  logic [2:0]  action_r;
  logic [7:0]  byte_r;
  logic [15:0] number_r;
  logic [5:0]  column_r;
  logic [1:0]  row_r;
  logic        load;

  assign in_ready  = !buf_v_r || job_ready;
  assign load      = in_valid && in_ready;
  assign job_valid = buf_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_v_r <= 1'b0;
    end else if (load) begin
      buf_v_r <= 1'b1;
    end else if (job_ready) begin
      buf_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      action_r <= in_action;
      byte_r   <= in_byte_value;
      number_r <= in_number;
      column_r <= in_column;
      row_r    <= in_row;
    end
  end

  always_comb begin
    logic [7:0] base;
    base      = (row_r == ROW_TOP) ? ROW_TOP_BASE : ROW_BOTTOM_BASE;
    job.mode  = MODE_NONE;
    job.rs    = RS_CMD;
    job.data  = byte_r;
    job.rem   = number_r;
    // leading digit position: 0 is the ten-thousands
    if (number_r >= 16'd10000) begin
      job.pow = 3'd0;
    end else if (number_r >= 16'd1000) begin
      job.pow = 3'd1;
    end else if (number_r >= 16'd100) begin
      job.pow = 3'd2;
    end else if (number_r >= 16'd10) begin
      job.pow = 3'd3;
    end else begin
      job.pow = POW_LAST;
    end
    case (action_t'(action_r))
      ACT_INIT: begin
        job.mode = MODE_INIT;
      end
      ACT_CMD: begin
        job.mode = MODE_BYTE;
      end
      ACT_CHAR: begin
        job.mode = MODE_BYTE;
        job.rs   = RS_DATA;
      end
      ACT_NUMBER: begin
        job.mode = MODE_DEC;
        job.rs   = RS_DATA;
      end
      ACT_CURSOR: begin
        if (row_r == ROW_TOP || row_r == ROW_BOTTOM) begin
          job.mode = MODE_BYTE;
          job.data = {2'b00, column_r} + 8'hFF + base;  // wraps at 8 bits
        end
      end
      default: begin
        job.mode = MODE_NONE;
      end
    endcase
  end

endmodule

// ===== sv/clnw_emit.sv =====
// Nibble sequencer and output register: one nibble per cycle from the held job while out_ready allows.
module clnw_emit
  import clnw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       job_valid,
  output logic       job_ready,
  input  job_t       job,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_nibble,
  output logic       out_register_select,
  output logic       out_last
);

  logic        act_r;
  mode_t       mode_r;
  logic        rs_r;
  logic [7:0]  data_r;
  logic [15:0] rem_r;
  logic [2:0]  pow_r;
  logic [3:0]  step_r;

  logic        out_valid_r;
  logic [3:0]  out_nibble_r;
  logic        out_rs_r;
  logic        out_last_r;

  logic        emit;
  logic        take;
  logic [3:0]  nib_nxt;
  logic        last_nxt;
  logic [3:0]  digit;
  logic [15:0] rem_nxt;

  assign emit      = act_r && (!out_valid_r || out_ready);
  assign job_ready = !act_r || (emit && last_nxt);
  assign take      = job_valid && job_ready;

  // Current decimal digit: parallel compares against k * pow10(pow).
  always_comb begin
    logic [17:0] pw;
    logic [17:0] rem_ext;
    logic [17:0] prod;
    logic [17:0] kp;
    pw      = {4'b0000, pow10(pow_r)};
    rem_ext = {2'b00, rem_r};
    digit   = 4'd0;
    prod    = 18'd0;
    for (int k = 1; k <= 9; k++) begin
      kp = 18'(k) * pw;
      if (rem_ext >= kp) begin
        digit = 4'(k);
        prod  = kp;
      end
    end
    rem_nxt = rem_r - prod[15:0];
  end

  always_comb begin
    nib_nxt  = 4'h0;
    last_nxt = 1'b0;
    case (mode_r)
      MODE_INIT: begin
        nib_nxt  = init_nibble(step_r);
        last_nxt = (step_r == INIT_LAST);
      end
      MODE_BYTE: begin
        nib_nxt  = step_r[0] ? data_r[3:0] : data_r[7:4];
        last_nxt = step_r[0];
      end
      MODE_DEC: begin
        nib_nxt  = step_r[0] ? digit : DIGIT_HI;
        last_nxt = step_r[0] && (pow_r == POW_LAST);
      end
      default: begin
        nib_nxt  = 4'h0;
        last_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        act_r <= (job.mode != MODE_NONE);
      end else if (emit && last_nxt) begin
        act_r <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      mode_r <= job.mode;
      rs_r   <= job.rs;
      data_r <= job.data;
      rem_r  <= job.rem;
      pow_r  <= job.pow;
      step_r <= 4'd0;
    end else if (emit) begin
      step_r <= step_r + 4'd1;
      if (mode_r == MODE_DEC && step_r[0]) begin
        rem_r <= rem_nxt;
        pow_r <= pow_r + 3'd1;
      end
    end
    if (emit) begin
      out_nibble_r <= nib_nxt;
      out_rs_r     <= rs_r;
      out_last_r   <= last_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_nibble          = out_nibble_r;
  assign out_register_select = out_rs_r;
  assign out_last            = out_last_r;

`include "char_lcd_nibble_writer_unit_assert.svh"

  `CLNW_ASSERT_NOW(a_dec_pow_range, act_r && mode_r == MODE_DEC, pow_r <= POW_LAST, "pow overrun")
  `CLNW_ASSERT_NOW(a_byte_steps, act_r && mode_r == MODE_BYTE, step_r <= 4'd1, "byte job overran")
  `CLNW_ASSERT_NOW(a_init_steps, act_r && mode_r == MODE_INIT, step_r <= INIT_LAST, "init overran")
  `CLNW_ASSERT_NEXT(a_last_retires, emit && last_nxt && !take, !act_r, "job outlived last nibble")

endmodule

// ===== sv/char_lcd_nibble_writer_unit.sv =====
// Character LCD 4-bit front end: turns one request into a run of nibble writes, each tagged
// with register select and a last flag. The input register takes a new request whenever the
// sequencer is free or is handing out the final nibble of its current job, so requests follow
// one another without gaps. The output register sends one nibble per cycle while out_ready
// allows; a request has 12 nibbles for init, 2 for a command, character or cursor move,
// 2 to 10 for a decimal number (two per digit), and none for a request that produces
// nothing (cursor row 0 or 3, unused action codes). A request passes the input register,
// the sequencer and the output register before its first nibble appears.
module char_lcd_nibble_writer_unit
  import clnw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_action,
  input  logic [7:0]  in_byte_value,
  input  logic [15:0] in_number,
  input  logic [5:0]  in_column,
  input  logic [1:0]  in_row,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_nibble,
  output logic        out_register_select,
  output logic        out_last
);

  logic job_valid;
  logic job_ready;
  job_t job;

  clnw_in_stage u_in_stage (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_byte_value (in_byte_value),
    .in_number     (in_number),
    .in_column     (in_column),
    .in_row        (in_row),
    .job_valid     (job_valid),
    .job_ready     (job_ready),
    .job           (job)
  );

  clnw_emit u_emit (
    .clk                 (clk),
    .rst_n               (rst_n),
    .job_valid           (job_valid),
    .job_ready           (job_ready),
    .job                 (job),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_nibble          (out_nibble),
    .out_register_select (out_register_select),
    .out_last            (out_last)
  );

endmodule

// ===== tb/lcd_nibble_checker.sv =====
// Scoreboard for the LCD nibble writer: predicts each request's nibble writes and checks them.
module lcd_nibble_checker
  import clnw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  in_action,
  input  logic [7:0]  in_byte_value,
  input  logic [15:0] in_number,
  input  logic [5:0]  in_column,
  input  logic [1:0]  in_row,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [3:0]  out_nibble,
  input  logic        out_register_select,
  input  logic        out_last,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [3:0] nibble;
    logic       rs;
    logic       last;
  } bus_write_t;

  bus_write_t writes_due[$];
  bus_write_t want;
  int         mismatches = 0;

  task automatic push_nibble(input logic [3:0] nib, input logic rs);
    bus_write_t w;
    w.nibble = nib;
    w.rs     = rs;
    w.last   = 1'b0;
    writes_due.push_back(w);
  endtask

  task automatic push_byte(input logic [7:0] b, input logic rs);
    push_nibble(b[7:4], rs);
    push_nibble(b[3:0], rs);
  endtask

  // Appends the bus writes one request causes; the final one carries last.
  task automatic predict_writes(input logic [2:0] act, input logic [7:0] bv,
                                input logic [15:0] num, input logic [5:0] col,
                                input logic [1:0] rw);
    int unsigned before_cnt;
    int unsigned p;
    bus_write_t  tail;
    before_cnt = writes_due.size();
    case (act)
      ACT_INIT: begin
        push_nibble(4'h3, RS_CMD);
        push_nibble(4'h3, RS_CMD);
        push_nibble(4'h3, RS_CMD);
        push_nibble(4'h2, RS_CMD);
        push_byte(8'h28, RS_CMD);
        push_byte(8'h08, RS_CMD);
        push_byte(8'h0C, RS_CMD);
        push_byte(8'h01, RS_CMD);
      end
      ACT_CMD:  push_byte(bv, RS_CMD);
      ACT_CHAR: push_byte(bv, RS_DATA);
      ACT_NUMBER: begin
        // leading zeros dropped, units digit always sent
        for (p = 10000; p != 0; p = p / 10)
          if (num >= p || p == 1)
            push_byte(8'h30 + 8'((num / p) % 10), RS_DATA);
      end
      ACT_CURSOR: begin
        // 8-bit wrap, so column 0 lands one below the row base
        if (rw == ROW_TOP)
          push_byte({2'b00, col} - 8'd1 + ROW_TOP_BASE, RS_CMD);
        else if (rw == ROW_BOTTOM)
          push_byte({2'b00, col} - 8'd1 + ROW_BOTTOM_BASE, RS_CMD);
      end
      default: ;
    endcase
    if (writes_due.size() > before_cnt) begin
      tail = writes_due.pop_back();
      tail.last = 1'b1;
      writes_due.push_back(tail);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        predict_writes(in_action, in_byte_value, in_number, in_column, in_row);
      if (out_valid && out_ready) begin
        if (writes_due.size() == 0) begin
          $error("unexpected nibble write: nibble %h rs %b last %b",
                 out_nibble, out_register_select, out_last);
          mismatches++;
        end else begin
          want = writes_due.pop_front();
          if (out_nibble !== want.nibble) begin
            $error("out_nibble: expected %h, got %h", want.nibble, out_nibble);
            mismatches++;
          end
          if (out_register_select !== want.rs) begin
            $error("out_register_select: expected %b, got %b", want.rs,
                   out_register_select);
            mismatches++;
          end
          if (out_last !== want.last) begin
            $error("out_last: expected %b, got %b", want.last, out_last);
            mismatches++;
          end
        end
      end
    end
    pending    <= writes_due.size();
    fail_count <= mismatches;
  end

endmodule

// ===== tb/tb_char_lcd_nibble_writer_unit.sv =====
// Testbench top for the LCD nibble writer: request stimulus, bus back-pressure and verdict.
module tb_char_lcd_nibble_writer_unit;
  import clnw_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_action;
  logic [7:0]  in_byte_value;
  logic [15:0] in_number;
  logic [5:0]  in_column;
  logic [1:0]  in_row;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_nibble;
  logic        out_register_select;
  logic        out_last;

  int fail_count;
  int pending;
  int ready_hold    = 0;
  int back_to_back  = 0;
  int quiet_cycles  = 0;
  int sent          = 0;

  localparam int QUIET_LIMIT = 1000;

  char_lcd_nibble_writer_unit uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_action           (in_action),
    .in_byte_value       (in_byte_value),
    .in_number           (in_number),
    .in_column           (in_column),
    .in_row              (in_row),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_nibble          (out_nibble),
    .out_register_select (out_register_select),
    .out_last            (out_last)
  );

  lcd_nibble_checker nibble_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_action           (in_action),
    .in_byte_value       (in_byte_value),
    .in_number           (in_number),
    .in_column           (in_column),
    .in_row              (in_row),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_nibble          (out_nibble),
    .out_register_select (out_register_select),
    .out_last            (out_last),
    .fail_count          (fail_count),
    .pending             (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Bus side: mostly ready, brief stalls, the odd long one, and ready-only stretches.
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      case ($urandom_range(0, 19))
        0, 1:          begin out_ready <= 1'b1; ready_hold <= $urandom_range(20, 60); end
        2:             begin out_ready <= 1'b0; ready_hold <= $urandom_range(10, 30); end
        3, 4, 5, 6, 7: begin out_ready <= 1'b0; ready_hold <= $urandom_range(0, 2); end
        default:       begin out_ready <= 1'b1; ready_hold <= $urandom_range(0, 3); end
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offers one request and returns at the edge where it transfers.
  task automatic offer_request(input logic [2:0] act, input logic [7:0] bv,
                               input logic [15:0] num, input logic [5:0] col,
                               input logic [1:0] rw);
    int gap;
    if (back_to_back > 0) begin
      back_to_back--;
      gap = 0;
    end else begin
      case ($urandom_range(0, 9))
        0:             gap = $urandom_range(8, 30);
        1, 2, 3:       gap = $urandom_range(1, 3);
        default:       gap = 0;
      endcase
      if ($urandom_range(0, 39) == 0)
        back_to_back = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_action     <= act;
    in_byte_value <= bv;
    in_number     <= num;
    in_column     <= col;
    in_row        <= rw;
    in_valid      <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  initial begin
    logic [2:0]  act;
    logic [7:0]  bv;
    logic [15:0] num;
    logic [5:0]  col;
    logic [1:0]  rw;
    in_valid      <= 1'b0;
    in_action     <= ACT_INIT;
    in_byte_value <= '0;
    in_number     <= '0;
    in_column     <= '0;
    in_row        <= '0;
    rst_n         <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every action, field extremes, digit-count boundaries, odd rows and columns
    offer_request(ACT_INIT, 8'($urandom), 16'($urandom), 6'($urandom), 2'($urandom));
    offer_request(ACT_CMD, 8'h00, 16'($urandom), 6'($urandom), 2'($urandom));
    offer_request(ACT_CMD, 8'hFF, 16'($urandom), 6'($urandom), 2'($urandom));
    offer_request(ACT_CHAR, 8'h00, 16'($urandom), 6'($urandom), 2'($urandom));
    offer_request(ACT_CHAR, 8'hFF, 16'($urandom), 6'($urandom), 2'($urandom));
    offer_request(ACT_CHAR, 8'hA5, 16'($urandom), 6'($urandom), 2'($urandom));
    offer_request(ACT_NUMBER, 8'($urandom), 16'd0, 6'($urandom), 2'($urandom));
    offer_request(ACT_NUMBER, 8'($urandom), 16'd9, 6'($urandom), 2'($urandom));
    offer_request(ACT_NUMBER, 8'($urandom), 16'd10, 6'($urandom), 2'($urandom));
    offer_request(ACT_NUMBER, 8'($urandom), 16'd999, 6'($urandom), 2'($urandom));
    offer_request(ACT_NUMBER, 8'($urandom), 16'd1000, 6'($urandom), 2'($urandom));
    offer_request(ACT_NUMBER, 8'($urandom), 16'd10000, 6'($urandom), 2'($urandom));
    offer_request(ACT_NUMBER, 8'($urandom), 16'd65535, 6'($urandom), 2'($urandom));
    offer_request(ACT_CURSOR, 8'($urandom), 16'($urandom), 6'd1, ROW_TOP);
    offer_request(ACT_CURSOR, 8'($urandom), 16'($urandom), 6'd40, ROW_BOTTOM);
    offer_request(ACT_CURSOR, 8'($urandom), 16'($urandom), 6'd0, ROW_TOP);
    offer_request(ACT_CURSOR, 8'($urandom), 16'($urandom), 6'd63, ROW_BOTTOM);
    offer_request(ACT_CURSOR, 8'($urandom), 16'($urandom), 6'd5, 2'd0);
    offer_request(ACT_CURSOR, 8'($urandom), 16'($urandom), 6'd5, 2'd3);
    offer_request(3'd5, 8'($urandom), 16'($urandom), 6'($urandom), 2'($urandom));
    offer_request(3'd6, 8'($urandom), 16'($urandom), 6'($urandom), 2'($urandom));
    offer_request(3'd7, 8'($urandom), 16'($urandom), 6'($urandom), 2'($urandom));
    offer_request(ACT_INIT, 8'($urandom), 16'($urandom), 6'($urandom), 2'($urandom));

    // random: tops the run up to the full request count
    while (sent < 450) begin
      bv  = 8'($urandom);
      num = 16'($urandom);
      col = 6'($urandom);
      rw  = 2'($urandom);
      case ($urandom_range(0, 99)) inside
        [0:3]:   act = ACT_INIT;
        [4:21]:  act = ACT_CMD;
        [22:41]: act = ACT_CHAR;
        [42:66]: act = ACT_NUMBER;
        [67:89]: act = ACT_CURSOR;
        default: act = 3'($urandom_range(5, 7));
      endcase
      if (act == ACT_NUMBER) begin
        case ($urandom_range(0, 3))
          0:       num = 16'($urandom_range(0, 99));
          1:       num = 16'($urandom_range(0, 9999));
          default: ;
        endcase
      end
      if (act == ACT_CURSOR) begin
        if ($urandom_range(0, 4) != 0) col = 6'($urandom_range(1, 40));
        if ($urandom_range(0, 4) != 0) rw  = 2'($urandom_range(1, 2));
      end
      offer_request(act, bv, num, col, rw);
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
